// File: src/tmfs_pkg.sv
package tmfs_pkg;

	localparam int SIDE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 8;
	// circumradius field width, fixed
	localparam int OUTER_BITS = 24;
	// operand slice of one partial product
	localparam int MUL_CHUNK = 24;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO     = 2'd1,
		ST_IMPROPER = 2'd2
	} status_t;

	function automatic int imax(input int x, input int y);
		return (x > y) ? x : y;
	endfunction

endpackage

// File: src/tmfs_if.sv
interface tmfs_side_if import tmfs_pkg::*; #(
	parameter int SIDE_BITS = SIDE_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [SIDE_BITS-1:0] side_a;
	logic [SIDE_BITS-1:0] side_b;
	logic [SIDE_BITS-1:0] side_c;

	modport source(output valid, side_a, side_b, side_c, input ready);
	modport sink(input valid, side_a, side_b, side_c, output ready);
endinterface

interface tmfs_metric_if import tmfs_pkg::*; #(
	parameter int SIDE_BITS = SIDE_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
);
	localparam int AREA_W = imax(1, 2*SIDE_BITS - FRAC_BITS - 1);

	logic                  valid;
	logic                  ready;
	logic [SIDE_BITS+1:0]  perimeter;
	logic [AREA_W-1:0]     area;
	logic [SIDE_BITS-1:0]  inner_radius;
	logic [OUTER_BITS-1:0] outer_radius;
	logic [SIDE_BITS-1:0]  height_on_a;
	logic [1:0]            status;

	modport source(output valid, perimeter, area, inner_radius, outer_radius, height_on_a,
		status, input ready);
	modport sink(input valid, perimeter, area, inner_radius, outer_radius, height_on_a,
		status, output ready);
endinterface

// File: src/tmfs_mul.sv
// Two-stage multiplier: partial products, then their sum.
module tmfs_mul import tmfs_pkg::*; #(
	parameter int A_W    = 16,
	parameter int B_W    = 16,
	parameter int SIDE_W = 1,
	parameter int CHUNK  = MUL_CHUNK
) (
	input  logic               clk,
	input  logic               en,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	input  logic [SIDE_W-1:0]  side_i,
	output logic [A_W+B_W-1:0] p,
	output logic [SIDE_W-1:0]  side_o
);
	localparam int NA  = (A_W + CHUNK - 1) / CHUNK;
	localparam int NB  = (B_W + CHUNK - 1) / CHUNK;
	localparam int P_W = A_W + B_W;

	logic [NA*CHUNK-1:0] a_ext;
	logic [NB*CHUNK-1:0] b_ext;
	logic [2*CHUNK-1:0]  pp_s1 [NA][NB];
	logic [SIDE_W-1:0]   side_s1;
	logic [P_W-1:0]      acc;
	logic [P_W-1:0]      p_s2;
	logic [SIDE_W-1:0]   side_s2;

	assign a_ext = (NA*CHUNK)'(a);
	assign b_ext = (NB*CHUNK)'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= (2*CHUNK)'(a_ext[i*CHUNK +: CHUNK]) *
						(2*CHUNK)'(b_ext[j*CHUNK +: CHUNK]);
				end
			end
			side_s1 <= side_i;
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (P_W'(pp_s1[i][j]) << ((i + j) * CHUNK));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2    <= acc;
			side_s2 <= side_s1;
		end
	end

	assign p      = p_s2;
	assign side_o = side_s2;
endmodule

// File: src/tmfs_root.sv
// Integer square root, one root bit per stage, IN_W/2 stages.
module tmfs_root import tmfs_pkg::*; #(
	parameter int IN_W   = 66,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                en,
	input  logic [IN_W-1:0]     x,
	input  logic [SIDE_W-1:0]   side_i,
	output logic [IN_W/2-1:0]   root,
	output logic [SIDE_W-1:0]   side_o
);
	localparam int R  = IN_W / 2;
	localparam int RW = R + 2;

	logic [RW-1:0]     rem_s  [1:R];
	logic [R-1:0]      root_s [1:R];
	logic [IN_W-1:0]   rad_s  [1:R];
	logic [SIDE_W-1:0] side_s [1:R];

	for (genvar k = 0; k < R; k++) begin : g_stage
		logic [RW-1:0]     cur_rem;
		logic [R-1:0]      cur_root;
		logic [IN_W-1:0]   cur_rad;
		logic [SIDE_W-1:0] cur_side;
		logic [RW+1:0]     cand;
		logic [RW+1:0]     trial;
		logic              take;

		if (k == 0) begin : g_first
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_rad  = x;
			assign cur_side = side_i;
		end else begin : g_next
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
			assign cur_rad  = rad_s[k];
			assign cur_side = side_s[k];
		end

		assign cand  = {cur_rem, cur_rad[IN_W-1 -: 2]};
		assign trial = (RW+2)'({cur_root, 2'b01});
		assign take  = cand >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? RW'(cand - trial) : RW'(cand);
				root_s[k+1] <= {cur_root[R-2:0], take};
				rad_s[k+1]  <= cur_rad << 2;
				side_s[k+1] <= cur_side;
			end
		end
	end

	assign root   = root_s[R];
	assign side_o = side_s[R];
endmodule

// File: src/tmfs_div.sv
// Restoring divider, saturating quotient of Q_W bits; one setup stage plus one bit a stage.
module tmfs_div import tmfs_pkg::*; #(
	parameter int X_W    = 33,
	parameter int D_W    = 19,
	parameter int Q_W    = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [X_W-1:0]    x,
	input  logic [D_W-1:0]    d,
	input  logic [SIDE_W-1:0] side_i,
	output logic [Q_W-1:0]    q,
	output logic [SIDE_W-1:0] side_o
);
	localparam int HI_W  = X_W - Q_W;
	localparam int CMP_W = imax(HI_W, D_W);

	logic [D_W-1:0]    rem_s  [Q_W+1];
	logic [Q_W-1:0]    quo_s  [Q_W+1];
	logic [Q_W-1:0]    lo_s   [Q_W+1];
	logic [D_W-1:0]    d_s    [Q_W+1];
	logic              sat_s  [Q_W+1];
	logic [SIDE_W-1:0] side_s [Q_W+1];
	logic [HI_W-1:0]   hi;

	assign hi = x[X_W-1:Q_W];

	// quotient would need more than Q_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[0]  <= CMP_W'(hi) >= CMP_W'(d);
			rem_s[0]  <= D_W'(hi);
			quo_s[0]  <= '0;
			lo_s[0]   <= x[Q_W-1:0];
			d_s[0]    <= d;
			side_s[0] <= side_i;
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_stage
		logic [D_W:0] cand;
		logic         take;

		assign cand = {rem_s[k-1], lo_s[k-1][Q_W-1]};
		assign take = cand >= {1'b0, d_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? D_W'(cand - {1'b0, d_s[k-1]}) : D_W'(cand);
				quo_s[k]  <= {quo_s[k-1][Q_W-2:0], take};
				lo_s[k]   <= lo_s[k-1] << 1;
				d_s[k]    <= d_s[k-1];
				sat_s[k]  <= sat_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign q      = sat_s[Q_W] ? '1 : quo_s[Q_W];
	assign side_o = side_s[Q_W];
endmodule

// File: src/triangle_metrics_from_sides.sv
// The longer of path A and path B sets the depth from accept to result valid.
// Throughput: one triangle per cycle while the skid entry is free; the circumradius
// divider (one quotient bit a stage) and the square roots (one root bit a stage) set
// the depth, not the rate.
// Reset: arst_n clears every valid bit asynchronously; payload registers are not reset.
module triangle_metrics_from_sides import tmfs_pkg::*; #(
	parameter int SIDE_BITS = SIDE_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	tmfs_side_if.sink      sides,
	tmfs_metric_if.source  metrics
);
	// widths
	localparam int PW   = SIDE_BITS + 2;             // perimeter
	localparam int FW   = SIDE_BITS + 1;             // b+c-a and friends
	localparam int QW   = 4*SIDE_BITS + 2;           // Q = 16*area^2, raw units
	localparam int SW   = 2*SIDE_BITS + 1;           // isqrt(Q)
	localparam int ABW  = 2*SIDE_BITS;
	localparam int ABCW = 3*SIDE_BITS;
	localparam int NW   = 6*SIDE_BITS;               // (abc)^2
	localparam int AW   = imax(1, 2*SIDE_BITS - FRAC_BITS - 1);
	localparam int RQB  = 2*OUTER_BITS;              // bits of (abc)^2 / Q kept
	localparam int DXW  = imax(NW, RQB) + 1;

	// path depths after the Q product
	localparam int LA = SW + SIDE_BITS + 1;          // isqrt then divide
	localparam int LB = 2 + RQB + 1 + OUTER_BITS;    // square, divide, isqrt
	localparam int LM = imax(LA, LB);
	localparam int DA = LM - LA;
	localparam int DB = LM - LB;
	localparam int LV = 4 + LM;

	localparam int BA_W = PW + AW + 2*SIDE_BITS;
	localparam int BB_W = 2 + OUTER_BITS;

	typedef struct packed {
		logic [PW-1:0]         perimeter;
		logic [AW-1:0]         area;
		logic [SIDE_BITS-1:0]  inner_radius;
		logic [OUTER_BITS-1:0] outer_radius;
		logic [SIDE_BITS-1:0]  height_on_a;
		logic [1:0]            status;
	} metrics_t;

	logic en;

	// ---------------------------------------------------------------------
	// Stage 1: perimeter, the three Heron factors and the status code.
	// The factors are only meaningful for a proper triangle.
	// ---------------------------------------------------------------------
	logic [PW-1:0] a_x, b_x, c_x;
	logic          zero_side, improper;
	logic [1:0]    st_in;

	assign a_x = PW'(sides.side_a);
	assign b_x = PW'(sides.side_b);
	assign c_x = PW'(sides.side_c);

	assign zero_side = (sides.side_a == '0) || (sides.side_b == '0) || (sides.side_c == '0);
	assign improper  = (a_x >= b_x + c_x) || (b_x >= a_x + c_x) || (c_x >= a_x + b_x);

	always_comb begin
		priority if (zero_side) begin
			st_in = ST_ZERO;
		end else if (improper) begin
			st_in = ST_IMPROPER;
		end else begin
			st_in = ST_OK;
		end
	end

	logic [PW-1:0]        per_s1;
	logic [FW-1:0]        f1_s1, f2_s1, f3_s1;
	logic [SIDE_BITS-1:0] a_s1, b_s1, c_s1;
	logic [1:0]           st_s1;
	logic                 v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sides.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			per_s1 <= a_x + b_x + c_x;
			f1_s1  <= FW'(b_x + c_x - a_x);
			f2_s1  <= FW'(a_x + c_x - b_x);
			f3_s1  <= FW'(a_x + b_x - c_x);
			a_s1   <= sides.side_a;
			b_s1   <= sides.side_b;
			c_s1   <= sides.side_c;
			st_s1  <= st_in;
		end
	end

	assign sides.ready = en;

	// ---------------------------------------------------------------------
	// First products: P*f1, f2*f3, a*b
	// ---------------------------------------------------------------------
	logic [PW+FW-1:0]     m1_p;
	logic [2*FW-1:0]      m2_p;
	logic [ABW-1:0]       ab_p;
	logic [1:0]           st_m1;
	logic [PW-1:0]        per_m1;
	logic [SIDE_BITS-1:0] a_m1, c_m1;

	tmfs_mul #(.A_W(PW), .B_W(FW), .SIDE_W(2 + PW)) u_m1 (
		.clk(clk), .en(en), .a(per_s1), .b(f1_s1),
		.side_i({st_s1, per_s1}), .p(m1_p), .side_o({st_m1, per_m1})
	);

	tmfs_mul #(.A_W(FW), .B_W(FW), .SIDE_W(SIDE_BITS)) u_m2 (
		.clk(clk), .en(en), .a(f2_s1), .b(f3_s1),
		.side_i(a_s1), .p(m2_p), .side_o(a_m1)
	);

	tmfs_mul #(.A_W(SIDE_BITS), .B_W(SIDE_BITS), .SIDE_W(SIDE_BITS)) u_ab (
		.clk(clk), .en(en), .a(a_s1), .b(b_s1),
		.side_i(c_s1), .p(ab_p), .side_o(c_m1)
	);

	// ---------------------------------------------------------------------
	// Second products: Q = 16*area^2 and abc
	// ---------------------------------------------------------------------
	logic [PW+3*FW-1:0]   q_p;
	logic [QW-1:0]        q_m2;
	logic [ABCW-1:0]      abc_p;
	logic [PW-1:0]        per_m2;
	logic [SIDE_BITS-1:0] a_m2;
	logic [1:0]           st_m2;

	tmfs_mul #(.A_W(PW + FW), .B_W(2*FW), .SIDE_W(PW + SIDE_BITS)) u_q (
		.clk(clk), .en(en), .a(m1_p), .b(m2_p),
		.side_i({per_m1, a_m1}), .p(q_p), .side_o({per_m2, a_m2})
	);

	// Q stays below 3*2^(4*SIDE_BITS) for any proper triangle
	assign q_m2 = QW'(q_p);

	tmfs_mul #(.A_W(ABW), .B_W(SIDE_BITS), .SIDE_W(2)) u_abc (
		.clk(clk), .en(en), .a(ab_p), .b(c_m1),
		.side_i(st_m1), .p(abc_p), .side_o(st_m2)
	);

	// ---------------------------------------------------------------------
	// Path A: s = isqrt(Q). area = s >> (FRAC_BITS+2), inradius = s / 2P,
	// height = s / 2a, all exact floors of the real values.
	// ---------------------------------------------------------------------
	logic [SW-1:0]        s_r;
	logic [PW-1:0]        per_r;
	logic [SIDE_BITS-1:0] a_r;
	logic [AW-1:0]        area_r;
	logic [SIDE_BITS-1:0] inner_d, height_d;
	logic [AW-1:0]        area_d;
	logic [PW-1:0]        per_d;

	tmfs_root #(.IN_W(QW), .SIDE_W(PW + SIDE_BITS)) u_sqrt_q (
		.clk(clk), .en(en), .x(q_m2),
		.side_i({per_m2, a_m2}), .root(s_r), .side_o({per_r, a_r})
	);

	assign area_r = AW'(s_r >> (FRAC_BITS + 2));

	tmfs_div #(.X_W(SW), .D_W(PW + 1), .Q_W(SIDE_BITS), .SIDE_W(AW)) u_inner (
		.clk(clk), .en(en), .x(s_r), .d({per_r, 1'b0}),
		.side_i(area_r), .q(inner_d), .side_o(area_d)
	);

	tmfs_div #(.X_W(SW), .D_W(SIDE_BITS + 1), .Q_W(SIDE_BITS), .SIDE_W(PW)) u_height (
		.clk(clk), .en(en), .x(s_r), .d({a_r, 1'b0}),
		.side_i(per_r), .q(height_d), .side_o(per_d)
	);

	// ---------------------------------------------------------------------
	// Path B: circumradius = isqrt((abc)^2 / Q), saturating once the
	// quotient reaches 2^(2*OUTER_BITS).
	// ---------------------------------------------------------------------
	logic [NW-1:0]         n_p;
	logic [QW-1:0]         q_n;
	logic [1:0]            st_n, st_dv, st_b;
	logic [RQB-1:0]        ratio;
	logic [OUTER_BITS-1:0] outer_b;

	tmfs_mul #(.A_W(ABCW), .B_W(ABCW), .SIDE_W(2 + QW)) u_n (
		.clk(clk), .en(en), .a(abc_p), .b(abc_p),
		.side_i({st_m2, q_m2}), .p(n_p), .side_o({st_n, q_n})
	);

	tmfs_div #(.X_W(DXW), .D_W(QW), .Q_W(RQB), .SIDE_W(2)) u_outer_div (
		.clk(clk), .en(en), .x(DXW'(n_p)), .d(q_n),
		.side_i(st_n), .q(ratio), .side_o(st_dv)
	);

	tmfs_root #(.IN_W(RQB), .SIDE_W(2)) u_outer_root (
		.clk(clk), .en(en), .x(ratio),
		.side_i(st_dv), .root(outer_b), .side_o(st_b)
	);

	// ---------------------------------------------------------------------
	// Line the two paths up
	// ---------------------------------------------------------------------
	logic [BA_W-1:0] bus_a, bus_a_al;
	logic [BB_W-1:0] bus_b, bus_b_al;

	assign bus_a = {per_d, area_d, inner_d, height_d};
	assign bus_b = {st_b, outer_b};

	if (DA > 0) begin : g_dly_a
		logic [BA_W-1:0] dla_s [DA];
		always_ff @(posedge clk) begin
			if (en) begin
				dla_s[0] <= bus_a;
				for (int i = 1; i < DA; i++) begin
					dla_s[i] <= dla_s[i-1];
				end
			end
		end
		assign bus_a_al = dla_s[DA-1];
	end else begin : g_no_dly_a
		assign bus_a_al = bus_a;
	end

	if (DB > 0) begin : g_dly_b
		logic [BB_W-1:0] dlb_s [DB];
		always_ff @(posedge clk) begin
			if (en) begin
				dlb_s[0] <= bus_b;
				for (int i = 1; i < DB; i++) begin
					dlb_s[i] <= dlb_s[i-1];
				end
			end
		end
		assign bus_b_al = dlb_s[DB-1];
	end else begin : g_no_dly_b
		assign bus_b_al = bus_b;
	end

	// valid bits follow the items down the pipe
	logic [LV-1:0] v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LV-2:0], v_s1};
		end
	end

	// ---------------------------------------------------------------------
	// Final item: a degenerate or zero-side triangle keeps only its status and perimeter
	// ---------------------------------------------------------------------
	logic                  fin_v;
	metrics_t              fin_d;
	logic [PW-1:0]         fin_per;
	logic [AW-1:0]         fin_area;
	logic [SIDE_BITS-1:0]  fin_inner, fin_height;
	logic [1:0]            fin_st;
	logic [OUTER_BITS-1:0] fin_outer;
	logic                  fin_ok;

	assign {fin_per, fin_area, fin_inner, fin_height} = bus_a_al;
	assign {fin_st, fin_outer} = bus_b_al;
	assign fin_ok = (fin_st == ST_OK);
	assign fin_v  = v_q[LV-1];

	always_comb begin
		fin_d.perimeter    = fin_per;
		fin_d.status       = fin_st;
		fin_d.area         = fin_ok ? fin_area : '0;
		fin_d.inner_radius = fin_ok ? fin_inner : '0;
		fin_d.outer_radius = fin_ok ? fin_outer : '0;
		fin_d.height_on_a  = fin_ok ? fin_height : '0;
	end

	// ---------------------------------------------------------------------
	// Output register plus skid entry. The pipe moves whenever the skid
	// entry is free, so input ready is a flop and one item can land in the
	// skid entry while the output item waits.
	// ---------------------------------------------------------------------
	logic     out_v_q, skid_v_q;
	metrics_t out_d_q, skid_d_q;

	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || metrics.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= fin_v;
			end
		end else if (fin_v && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || metrics.ready) begin
			out_d_q <= skid_v_q ? skid_d_q : fin_d;
		end else if (!skid_v_q) begin
			skid_d_q <= fin_d;
		end
	end

	assign metrics.valid        = out_v_q;
	assign metrics.perimeter    = out_d_q.perimeter;
	assign metrics.area         = out_d_q.area;
	assign metrics.inner_radius = out_d_q.inner_radius;
	assign metrics.outer_radius = out_d_q.outer_radius;
	assign metrics.height_on_a  = out_d_q.height_on_a;
	assign metrics.status       = out_d_q.status;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds an item while output register is empty");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !metrics.ready))
		else $error("skid entry filled without an output stall");

	a_bad_triangle_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(metrics.valid && metrics.status != ST_OK) |->
		(metrics.area == '0 && metrics.inner_radius == '0 &&
		metrics.outer_radius == '0 && metrics.height_on_a == '0))
		else $error("degenerate triangle item carries nonzero metrics");
`endif

endmodule
